>>> hdl/all_pairs_shortest_path_assert.svh
// Assertion macros for the shortest path block
`ifndef ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH

`ifndef SYNTHESIS
`define APSP_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define APSP_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define APSP_ASSERT_IMPLY(label, clk, rst, a, b)
`define APSP_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

>>> hdl/apsp_pkg.sv
`default_nettype none
package apsp_pkg;

  localparam int MaxNodesDefault = 64;
  localparam int DistWidth = 24;
  localparam logic [6:0] NodeCountReset = 7'd64;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] weight;
    logic               absent;
  } in_req_t;

  typedef struct packed {
    logic signed [DistWidth-1:0] distance;
    logic                        unreachable;
  } out_resp_t;

  typedef struct packed {
    logic                        unr;
    logic signed [DistWidth-1:0] val;
  } dist_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_DIAG,
    S_LOAD,
    S_ROWK,
    S_ROWW,
    S_STEPR,
    S_STEPW
  } state_t;

endpackage
`default_nettype wire

>>> hdl/all_pairs_shortest_path.sv
// All-pairs shortest path over a stored distance matrix.
// in_valid/in_ready carries requests: write one entry, run relaxation,
// read one entry. Reads return one response on out_valid/out_ready.
// cfg_wen/cfg_wdata set node_count (vertices in use); write only when idle.
// Write and ignored requests complete in the idle state. A read moves
// through S_RDWAIT, which registers the memory data into out_data, and
// out_valid rises after it. The next request is taken once the response
// has left the output register; a stalled receiver holds off further requests.
// A run makes n diagonal writes, then per pivot k loads row k into the
// cell chain, and per row reads d[i][k] and rotates the chain through all
// MAX_NODES columns, with an extra step for each active column (the single
// memory read and write-back of d[i][j]). Requests wait during the run.
// Reset returns the control to idle and node_count to 64; the distance
// memory is not cleared, every entry must be written before a run.
`default_nettype none
`include "all_pairs_shortest_path_assert.svh"
module all_pairs_shortest_path import apsp_pkg::*; #(
  parameter int MAX_NODES = MaxNodesDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_req_t   in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_resp_t      out_data,
  input  wire logic      cfg_wen,
  input  wire logic [6:0] cfg_wdata
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int Depth = MAX_NODES * MAX_NODES;
  localparam int AW = $clog2(Depth);
  localparam logic [NW-1:0] JLast = NW'(MAX_NODES - 1);
  localparam logic [CW-1:0] CntMax = CW'(MAX_NODES);

  function automatic logic [AW-1:0] addr_of(input logic [NW-1:0] r, input logic [NW-1:0] c);
    addr_of = AW'(r) * AW'(MAX_NODES) + AW'(c);
  endfunction

  state_t state, state_next;
  logic [6:0] node_count;
  logic [CW-1:0] nact;
  logic [NW-1:0] ii, ii_next, jj, jj_next, kk, kk_next;
  logic [CW-1:0] cnt, cnt_next;
  dist_entry_t dik;
  logic rd_oob;

  dist_entry_t mem [Depth];
  dist_entry_t rdata, wdata;
  logic [AW-1:0] raddr, waddr;
  logic mem_we;

  dist_entry_t ring_q [MAX_NODES];
  dist_entry_t tail;
  logic shift_en;

  logic upd;
  dist_entry_t relaxed;

  logic acc, in_range;
  logic [AW-1:0] req_addr;
  dist_entry_t req_entry;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign acc = in_valid && in_ready;
  assign in_range = (int'(in_data.row) < MAX_NODES) && (int'(in_data.col) < MAX_NODES);
  assign req_addr = AW'(in_data.row) * AW'(MAX_NODES) + AW'(in_data.col);
  assign req_entry.unr = in_data.absent;
  assign req_entry.val = in_data.absent ? '0 : DistWidth'(in_data.weight);

  always_comb begin
    if (node_count == 7'd0) begin
      nact = CW'(1);
    end else if (int'(node_count) > MAX_NODES) begin
      nact = CntMax;
    end else begin
      nact = CW'(node_count);
    end
  end

  generate
    for (genvar c = 0; c < MAX_NODES; c++) begin : g_chain
      dist_entry_t d_in;
      if (c == MAX_NODES - 1) begin : g_tail
        assign d_in = tail;
      end else begin : g_mid
        assign d_in = ring_q[c+1];
      end
      apsp_cell u_cell (
        .clk  (clk),
        .en   (shift_en),
        .d_in (d_in),
        .q    (ring_q[c])
      );
    end
  endgenerate

  apsp_relax u_relax (
    .dik (dik),
    .dkj (ring_q[0]),
    .dij (rdata),
    .upd (upd),
    .res (relaxed)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      node_count <= NodeCountReset;
      out_valid <= 1'b0;
      ii <= '0;
      jj <= '0;
      kk <= '0;
      cnt <= '0;
    end else begin
      state <= state_next;
      ii <= ii_next;
      jj <= jj_next;
      kk <= kk_next;
      cnt <= cnt_next;
      if (cfg_wen) begin
        node_count <= cfg_wdata;
      end
      if (state == S_RDWAIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_oob <= !in_range;
    end
    if (state == S_RDWAIT) begin
      if (rd_oob || rdata.unr) begin
        out_data.distance <= '0;
        out_data.unreachable <= 1'b1;
      end else begin
        out_data.distance <= rdata.val;
        out_data.unreachable <= 1'b0;
      end
    end
    if (state == S_ROWW) begin
      dik <= rdata;
    end else if (state == S_STEPW && jj == kk && upd) begin
      dik <= relaxed;
    end
  end

  always_comb begin
    state_next = state;
    ii_next = ii;
    jj_next = jj;
    kk_next = kk;
    cnt_next = cnt;
    mem_we = 1'b0;
    waddr = addr_of(ii, jj);
    wdata = relaxed;
    raddr = addr_of(ii, jj);
    shift_en = 1'b0;
    tail = ring_q[0];
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (in_data.operation)
            OP_WRITE: begin
              mem_we = in_range;
              waddr = req_addr;
              wdata = req_entry;
            end
            OP_RUN: begin
              ii_next = '0;
              state_next = S_DIAG;
            end
            OP_READ: begin
              raddr = req_addr;
              state_next = S_RDWAIT;
            end
            OP_NONE: begin
            end
          endcase
        end
      end
      S_RDWAIT: begin
        state_next = S_IDLE;
      end
      S_DIAG: begin
        mem_we = 1'b1;
        waddr = addr_of(ii, ii);
        wdata = '0;
        if (CW'(ii) == nact - CW'(1)) begin
          kk_next = '0;
          cnt_next = '0;
          state_next = S_LOAD;
        end else begin
          ii_next = ii + NW'(1);
        end
      end
      S_LOAD: begin
        raddr = addr_of(kk, cnt[NW-1:0]);
        shift_en = (cnt != '0);
        tail = rdata;
        cnt_next = cnt + CW'(1);
        if (cnt == CntMax) begin
          ii_next = '0;
          state_next = S_ROWK;
        end
      end
      S_ROWK: begin
        raddr = addr_of(ii, kk);
        state_next = S_ROWW;
      end
      S_ROWW: begin
        jj_next = '0;
        state_next = S_STEPR;
      end
      S_STEPR, S_STEPW: begin
        if (state == S_STEPR && CW'(jj) < nact) begin
          raddr = addr_of(ii, jj);
          state_next = S_STEPW;
        end else begin
          shift_en = 1'b1;
          if (state == S_STEPW) begin
            mem_we = upd;
            if (ii == kk && upd) begin
              tail = relaxed;
            end
          end
          if (jj == JLast) begin
            if (CW'(ii) == nact - CW'(1)) begin
              if (CW'(kk) == nact - CW'(1)) begin
                state_next = S_IDLE;
              end else begin
                kk_next = kk + NW'(1);
                cnt_next = '0;
                state_next = S_LOAD;
              end
            end else begin
              ii_next = ii + NW'(1);
              state_next = S_ROWK;
            end
          end else begin
            jj_next = jj + NW'(1);
            state_next = S_STEPR;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `APSP_ASSERT_NEXT(a_read_wait, clk, rst, acc && in_data.operation == OP_READ, state == S_RDWAIT)
  `APSP_ASSERT_NEXT(a_read_resp, clk, rst, state == S_RDWAIT, out_valid)
  `APSP_ASSERT_NEXT(a_run_start, clk, rst, acc && in_data.operation == OP_RUN, state == S_DIAG)
  `APSP_ASSERT_IMPLY(a_step_active, clk, rst, state == S_STEPW, CW'(jj) < nact)

endmodule
`default_nettype wire

>>> hdl/apsp_cell.sv
`default_nettype none
module apsp_cell import apsp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire dist_entry_t d_in,
  output dist_entry_t      q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d_in;
    end
  end

endmodule
`default_nettype wire

>>> hdl/apsp_relax.sv
`default_nettype none
module apsp_relax import apsp_pkg::*; (
  input  wire dist_entry_t dik,
  input  wire dist_entry_t dkj,
  input  wire dist_entry_t dij,
  output logic             upd,
  output dist_entry_t      res
);

  localparam logic signed [DistWidth-1:0] DMax = {1'b0, {(DistWidth-1){1'b1}}};
  localparam logic signed [DistWidth-1:0] DMin = {1'b1, {(DistWidth-1){1'b0}}};

  logic signed [DistWidth:0]   sum;
  logic signed [DistWidth-1:0] sat;

  always_comb begin
    sum = {dik.val[DistWidth-1], dik.val} + {dkj.val[DistWidth-1], dkj.val};
    if (sum[DistWidth] != sum[DistWidth-1]) begin
      sat = sum[DistWidth] ? DMin : DMax;
    end else begin
      sat = sum[DistWidth-1:0];
    end
    upd = !dik.unr && !dkj.unr && (dij.unr || (sat < dij.val));
    res.unr = 1'b0;
    res.val = sat;
  end

endmodule
`default_nettype wire
